// ===== src/pgtm_pkg.sv =====
// Package for the pressure gauge threshold monitor.
// Register indexes, LED and fault event codes, and the per-gauge state type.
// No dependencies.
package pgtm_pkg;

	localparam int THR_REGS = 3;

	localparam logic [2:0] REG_ZERO_CODE   = 3'd0;
	localparam logic [2:0] REG_SLOPE_Q8    = 3'd1;
	localparam logic [2:0] REG_BASE        = 3'd2;
	localparam logic [2:0] REG_VALID_WIN   = 3'd3;
	localparam logic [2:0] REG_FAULT_LIMIT = 3'd4;
	localparam logic [2:0] REG_THR_GAUGE0  = 3'd5;
	localparam logic [2:0] REG_THR_GAUGE1  = 3'd6;
	localparam logic [2:0] REG_THR_GAUGE2  = 3'd7;

	localparam logic [1:0] LED_OFF   = 2'd0;
	localparam logic [1:0] LED_GREEN = 2'd1;
	localparam logic [1:0] LED_BLUE  = 2'd2;
	localparam logic [1:0] LED_RED   = 2'd3;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_LOW  = 2'd1;
	localparam logic [1:0] EV_HIGH = 2'd2;

	localparam logic [11:0] ZERO_CODE_RST   = 12'd0;
	localparam logic [15:0] SLOPE_RST       = 16'd256;
	localparam logic [15:0] BASE_RST        = 16'd0;
	localparam logic [31:0] VALID_WIN_RST   = 32'h7FFF_7FFF;
	localparam logic [7:0]  FAULT_LIMIT_RST = 8'd3;

	typedef struct packed {
		logic [7:0] low_cnt;
		logic [7:0] high_cnt;
		logic       low_flag;
		logic       high_flag;
		logic [1:0] led;
	} pgtm_state_t;

endpackage

// ===== src/pgtm_conv.sv =====
// Code-to-pressure conversion: ((code - zero) * slope) >>> 8 + base, saturated.
// Uses pgtm_pkg (nothing beyond the import convention).
module pgtm_conv import pgtm_pkg::*; (
	input  logic [11:0]        adc_code,
	input  logic [11:0]        zero_code,
	input  logic [15:0]        slope_q8,
	input  logic signed [15:0] base_pressure,
	output logic signed [15:0] pressure
);

	logic signed [12:0] diff;
	logic signed [29:0] prod;
	logic signed [21:0] quot;
	logic signed [22:0] sum;

	always_comb begin
		diff = $signed({1'b0, adc_code}) - $signed({1'b0, zero_code});
		prod = 30'(diff) * 30'($signed({1'b0, slope_q8}));
		// arithmetic shift: floor division by 256
		quot = prod[29:8];
		sum  = 23'(quot) + 23'(base_pressure);
		if (sum > 23'sd32767)
			pressure = 16'sh7FFF;
		else if (sum < -23'sd32768)
			pressure = 16'sh8000;
		else
			pressure = sum[15:0];
	end

endmodule

// ===== src/pgtm_check.sv =====
// Threshold check and fault counter update for one gauge.
// Uses pgtm_pkg for the state type, LED and event codes.
module pgtm_check import pgtm_pkg::*; (
	input  pgtm_state_t        cur,
	input  logic               run,
	input  logic signed [15:0] pressure,
	input  logic [31:0]        thresholds,
	input  logic [7:0]         fault_limit,
	output pgtm_state_t        nxt,
	output logic [1:0]         fault_event
);

	logic signed [15:0] lo;
	logic signed [15:0] hi;

	always_comb begin
		lo = thresholds[15:0];
		hi = thresholds[31:16];
		nxt = cur;
		fault_event = EV_NONE;
		if (run) begin
			if (pressure > lo && pressure < hi) begin
				nxt.low_cnt  = 8'd0;
				nxt.high_cnt = 8'd0;
				nxt.led      = LED_GREEN;
			end else begin
				// crossed thresholds: low steps first, high steps see their result
				if (pressure < lo && nxt.low_cnt <= fault_limit && nxt.low_cnt != 8'hFF) begin
					nxt.low_cnt  = nxt.low_cnt + 8'd1;
					nxt.high_cnt = 8'd0;
					if (nxt.low_cnt == fault_limit) begin
						nxt.low_flag = 1'b1;
						nxt.led      = LED_BLUE;
						fault_event  = EV_LOW;
					end
				end
				if (pressure > hi && nxt.high_cnt <= fault_limit && nxt.high_cnt != 8'hFF) begin
					nxt.high_cnt = nxt.high_cnt + 8'd1;
					nxt.low_cnt  = 8'd0;
					if (nxt.high_cnt == fault_limit) begin
						nxt.high_flag = 1'b1;
						nxt.led       = LED_RED;
						fault_event   = EV_HIGH;
					end
				end
			end
		end
	end

endmodule

// ===== src/pressure_gauge_threshold_monitor.sv =====
// Top level of the pressure gauge threshold monitor.
// Uses pgtm_pkg, pgtm_conv and pgtm_check.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_stall  | gauge_index, adc_code, run_checks
//  result   | out_valid / out_stall| gauge_echo, pressure, pressure_valid, led_code,
//           |                      | fault_event, low_fault_latched, high_fault_latched
//  config   | cfg_we               | cfg_index, cfg_data
//
// One item per cycle when not stalled; registered in input, then result register.
// Conversion, window check and gauge state update happen in the cycle an item
// moves from the input register to the result register, so back-to-back items
// on the same gauge see the updated counters.
// Reset clears handshake state, gauge state and config registers to defaults.
// A stalled result holds; the input register still fills, then in_stall rises.
module pressure_gauge_threshold_monitor import pgtm_pkg::*; #(
	parameter int GAUGE_COUNT = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         gauge_index,
	input  logic [11:0]        adc_code,
	input  logic               run_checks,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         gauge_echo,
	output logic signed [15:0] pressure,
	output logic               pressure_valid,
	output logic [1:0]         led_code,
	output logic [1:0]         fault_event,
	output logic               low_fault_latched,
	output logic               high_fault_latched,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int LIVE = (GAUGE_COUNT < THR_REGS) ? GAUGE_COUNT : THR_REGS;

	logic [11:0] zero_code_q;
	logic [15:0] slope_q;
	logic [15:0] base_q;
	logic [31:0] window_q;
	logic [7:0]  limit_q;
	logic [31:0] thr_q [THR_REGS];

	pgtm_state_t st_q [LIVE];

	logic        s1_valid;
	logic [1:0]  s1_gauge;
	logic [11:0] s1_code;
	logic        s1_run;

	logic               out_valid_s2;
	logic [1:0]         gauge_s2;
	logic signed [15:0] pressure_s2;
	logic               pvalid_s2;
	logic [1:0]         led_s2;
	logic [1:0]         event_s2;
	logic               lflag_s2;
	logic               hflag_s2;

	logic               s2_ready;
	logic               advance;
	logic               hit;
	pgtm_state_t        cur;
	pgtm_state_t        nxt;
	logic [31:0]        thr_sel;
	logic signed [15:0] p;
	logic signed [15:0] vmin;
	logic signed [15:0] vmax;
	logic [1:0]         ev;

	assign s2_ready = !out_valid_s2 || !out_stall;
	assign in_stall = s1_valid && !s2_ready;
	assign advance  = s1_valid && s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_code_q <= ZERO_CODE_RST;
			slope_q     <= SLOPE_RST;
			base_q      <= BASE_RST;
			window_q    <= VALID_WIN_RST;
			limit_q     <= FAULT_LIMIT_RST;
			for (int i = 0; i < THR_REGS; i++) thr_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ZERO_CODE:   zero_code_q <= cfg_data[11:0];
				REG_SLOPE_Q8:    slope_q     <= cfg_data[15:0];
				REG_BASE:        base_q      <= cfg_data[15:0];
				REG_VALID_WIN:   window_q    <= cfg_data;
				REG_FAULT_LIMIT: limit_q     <= cfg_data[7:0];
				REG_THR_GAUGE0:  thr_q[0]    <= cfg_data;
				REG_THR_GAUGE1:  thr_q[1]    <= cfg_data;
				REG_THR_GAUGE2:  thr_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!in_stall) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			s1_gauge <= gauge_index;
			s1_code  <= adc_code;
			s1_run   <= run_checks;
		end
	end

	// gauge state and threshold select
	always_comb begin
		hit = 1'b0;
		cur = '0;
		for (int i = 0; i < LIVE; i++) begin
			if (s1_gauge == 2'(i)) begin
				hit = 1'b1;
				cur = st_q[i];
			end
		end
		thr_sel = '0;
		for (int i = 0; i < THR_REGS; i++) begin
			if (s1_gauge == 2'(i)) thr_sel = thr_q[i];
		end
	end

	pgtm_conv u_conv (
		.adc_code      (s1_code),
		.zero_code     (zero_code_q),
		.slope_q8      (slope_q),
		.base_pressure (base_q),
		.pressure      (p)
	);

	pgtm_check u_check (
		.cur         (cur),
		.run         (s1_run && hit),
		.pressure    (p),
		.thresholds  (thr_sel),
		.fault_limit (limit_q),
		.nxt         (nxt),
		.fault_event (ev)
	);

	assign vmin = window_q[15:0];
	assign vmax = window_q[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIVE; i++) st_q[i] <= '0;
		end else if (advance) begin
			for (int i = 0; i < LIVE; i++) begin
				if (s1_gauge == 2'(i)) st_q[i] <= nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			out_valid_s2 <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gauge_s2    <= s1_gauge;
			pressure_s2 <= p;
			pvalid_s2   <= (p > vmin) && (p < vmax);
			led_s2      <= nxt.led;
			event_s2    <= ev;
			lflag_s2    <= nxt.low_flag;
			hflag_s2    <= nxt.high_flag;
		end
	end

	assign out_valid          = out_valid_s2;
	assign gauge_echo         = gauge_s2;
	assign pressure           = pressure_s2;
	assign pressure_valid     = pvalid_s2;
	assign led_code           = led_s2;
	assign fault_event        = event_s2;
	assign low_fault_latched  = lflag_s2;
	assign high_fault_latched = hflag_s2;

endmodule

// ===== src/pgtm_checker.sv =====
// Port-level assertions for the pressure gauge threshold monitor, and the bind.
// Uses pgtm_pkg for LED and event codes.
module pgtm_checker import pgtm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         gauge_echo,
	input logic signed [15:0] pressure,
	input logic [1:0]         led_code,
	input logic [1:0]         fault_event,
	input logic               low_fault_latched,
	input logic               high_fault_latched
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pressure) && $stable(fault_event))
		else $error("stalled result changed");

	// input only backs up behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	a_low_ev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault_event == EV_LOW |-> low_fault_latched && led_code == LED_BLUE)
		else $error("low fault event without flag or blue LED");

	a_high_ev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault_event == EV_HIGH |-> high_fault_latched && led_code == LED_RED)
		else $error("high fault event without flag or red LED");

	a_bad_gauge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gauge_echo == 2'd3 |->
			led_code == LED_OFF && fault_event == EV_NONE &&
			!low_fault_latched && !high_fault_latched)
		else $error("status reported for a nonexistent gauge");

endmodule

bind pressure_gauge_threshold_monitor pgtm_checker u_pgtm_checker (.*);

// ===== verif/tb_pressure_gauge_threshold_monitor.sv =====
// Self-checking testbench for pressure_gauge_threshold_monitor.
// Compares every result against a built-in gauge predictor; uses pgtm_pkg.
// Directed corner items first, then random bursts across register settings, then a long run at a high limit.
`timescale 1ns / 100ps

module tb_pressure_gauge_threshold_monitor;
	import pgtm_pkg::*;

	localparam int GAUGES = 3;
	localparam int HOLD_CYCLES = 300;

	localparam int MODE_FREE      = 0;
	localparam int MODE_SLOW_SRC  = 1;
	localparam int MODE_SLOW_SINK = 2;
	localparam int MODE_BOTH      = 3;

	localparam int BELOW   = 0;
	localparam int INSIDE  = 1;
	localparam int ABOVE   = 2;
	localparam int ON_EDGE = 3;

	typedef struct packed {
		logic [1:0]  gauge;
		logic [11:0] code;
		logic        chk;
	} sample_t;

	typedef struct packed {
		logic [1:0]         gauge;
		logic signed [15:0] pressure;
		logic               pvalid;
		logic [1:0]         led;
		logic [1:0]         fault;
		logic               lo_latched;
		logic               hi_latched;
	} reading_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         gauge_index = '0;
	logic [11:0]        adc_code = '0;
	logic               run_checks = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         gauge_echo;
	logic signed [15:0] pressure;
	logic               pressure_valid;
	logic [1:0]         led_code;
	logic [1:0]         fault_event;
	logic               low_fault_latched;
	logic               high_fault_latched;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	// mirror of the register file
	logic [11:0]        cfg_zero = ZERO_CODE_RST;
	logic [15:0]        cfg_slope = SLOPE_RST;
	logic signed [15:0] cfg_base = BASE_RST;
	logic [31:0]        cfg_window = VALID_WIN_RST;
	logic [7:0]         cfg_limit = FAULT_LIMIT_RST;
	logic [31:0]        thr [GAUGES] = '{default: '0};

	// per-gauge state
	logic [7:0] lo_cnt [GAUGES] = '{default: '0};
	logic [7:0] hi_cnt [GAUGES] = '{default: '0};
	logic       lo_flag [GAUGES] = '{default: 1'b0};
	logic       hi_flag [GAUGES] = '{default: 1'b0};
	logic [1:0] led_state [GAUGES] = '{default: LED_OFF};

	// codes that land exactly on each gauge's thresholds
	logic [11:0] lo_code [GAUGES] = '{default: '0};
	logic [11:0] hi_code [GAUGES] = '{default: '0};

	sample_t  pending [$];
	reading_t reading_q [$];
	sample_t  cur;
	int       idle_pct = 0;
	int       stall_pct = 0;
	int       errors = 0;
	int       hold_requests = 0;
	int       hold_served = 0;
	int       hold_left = 0;

	pressure_gauge_threshold_monitor #(.GAUGE_COUNT(GAUGES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.gauge_index(gauge_index),
		.adc_code(adc_code),
		.run_checks(run_checks),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.gauge_echo(gauge_echo),
		.pressure(pressure),
		.pressure_valid(pressure_valid),
		.led_code(led_code),
		.fault_event(fault_event),
		.low_fault_latched(low_fault_latched),
		.high_fault_latched(high_fault_latched),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int code_to_pressure(logic [11:0] code);
		longint q;
		q = (longint'(code) - longint'(cfg_zero)) * longint'(cfg_slope);
		q = (q >>> 8) + longint'(cfg_base);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return int'(q);
	endfunction

	function automatic reading_t predict_reading(sample_t s);
		reading_t r;
		int p;
		int lo;
		int hi;
		int g;
		p = code_to_pressure(s.code);
		g = s.gauge;
		r = '0;
		r.gauge = s.gauge;
		r.pressure = 16'(p);
		r.pvalid = (p > int'(shortint'(cfg_window[15:0]))) &&
			(p < int'(shortint'(cfg_window[31:16])));
		r.fault = EV_NONE;
		if (g < GAUGES && g < THR_REGS) begin
			if (s.chk) begin
				lo = shortint'(thr[g][15:0]);
				hi = shortint'(thr[g][31:16]);
				if (p > lo && p < hi) begin
					lo_cnt[g] = '0;
					hi_cnt[g] = '0;
					led_state[g] = LED_GREEN;
				end else begin
					if (p < lo && lo_cnt[g] <= cfg_limit && lo_cnt[g] != 8'hFF) begin
						lo_cnt[g]++;
						hi_cnt[g] = '0;
						if (lo_cnt[g] == cfg_limit) begin
							lo_flag[g] = 1'b1;
							r.fault = EV_LOW;
							led_state[g] = LED_BLUE;
						end
					end
					if (p > hi && hi_cnt[g] <= cfg_limit && hi_cnt[g] != 8'hFF) begin
						hi_cnt[g]++;
						lo_cnt[g] = '0;
						if (hi_cnt[g] == cfg_limit) begin
							hi_flag[g] = 1'b1;
							r.fault = EV_HIGH;
							led_state[g] = LED_RED;
						end
					end
				end
			end
			r.led = led_state[g];
			r.lo_latched = lo_flag[g];
			r.hi_latched = hi_flag[g];
		end
		return r;
	endfunction

	// source side
	always @(posedge clk) begin
		bit took;
		took = in_valid && !in_stall;
		if (took)
			reading_q.push_back(predict_reading(cur));
		if (!in_valid || took) begin
			if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
				cur = pending.pop_front();
				in_valid <= 1'b1;
				gauge_index <= cur.gauge;
				adc_code <= cur.code;
				run_checks <= cur.chk;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// sink backpressure, with an occasional long hold-off
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		reading_t want;
		reading_t got;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			got = '{gauge_echo, pressure, pressure_valid, led_code, fault_event,
				low_fault_latched, high_fault_latched};
			if (reading_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result gauge=%0d pressure=%0d", $time,
						got.gauge, got.pressure);
			end else begin
				want = reading_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: exp g=%0d p=%0d v=%0d led=%0d ev=%0d lf=%0d hf=%0d",
							$time, want.gauge, want.pressure, want.pvalid, want.led,
							want.fault, want.lo_latched, want.hi_latched);
						$display("%0t: got g=%0d p=%0d v=%0d led=%0d ev=%0d lf=%0d hf=%0d",
							$time, got.gauge, got.pressure, got.pvalid, got.led,
							got.fault, got.lo_latched, got.hi_latched);
					end
				end
			end
		end
	end

	task automatic add_item(logic [1:0] g, logic [11:0] code, logic chk);
		pending.push_back('{g, code, chk});
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ZERO_CODE:   cfg_zero = val[11:0];
			REG_SLOPE_Q8:    cfg_slope = val[15:0];
			REG_BASE:        cfg_base = val[15:0];
			REG_VALID_WIN:   cfg_window = val;
			REG_FAULT_LIMIT: cfg_limit = val[7:0];
			REG_THR_GAUGE0:  thr[0] = val;
			REG_THR_GAUGE1:  thr[1] = val;
			REG_THR_GAUGE2:  thr[2] = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending.size() != 0 || in_valid || reading_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_mode(int m);
		case (m)
			MODE_SLOW_SRC:  begin idle_pct = 60; stall_pct = 0; end
			MODE_SLOW_SINK: begin idle_pct = 0; stall_pct = 60; end
			MODE_BOTH:      begin idle_pct = 15; stall_pct = 15; end
			default:        begin idle_pct = 0; stall_pct = 0; end
		endcase
	endtask

	function automatic logic [11:0] pick_code(logic [1:0] g, int region);
		int gi;
		int lo;
		int hi;
		int p;
		logic [11:0] c;
		gi = (g < GAUGES) ? g : 0;
		lo = shortint'(thr[gi][15:0]);
		hi = shortint'(thr[gi][31:16]);
		if (region == ON_EDGE)
			return $urandom_range(1) ? lo_code[gi] : hi_code[gi];
		c = 12'($urandom_range(4095));
		for (int i = 0; i < 40; i++) begin
			c = 12'($urandom_range(4095));
			p = code_to_pressure(c);
			if ((region == BELOW && p < lo) || (region == ABOVE && p > hi) ||
				(region == INSIDE && p > lo && p < hi))
				return c;
		end
		return c;
	endfunction

	task automatic random_phase(int n_items, int mode, bit squeeze);
		logic [11:0] c1;
		logic [11:0] c2;
		logic [11:0] t;
		int pick;
		int b;
		int total;
		int len;
		int region;
		logic [1:0] g;
		set_mode(mode);
		write_reg(REG_ZERO_CODE, $urandom_range(4095));
		pick = $urandom_range(9);
		write_reg(REG_SLOPE_Q8, pick == 0 ? 32'd0 : pick == 1 ? 32'hFFFF :
			pick < 5 ? 32'd256 : $urandom_range(1, 1024));
		pick = $urandom_range(9);
		b = $urandom_range(4000) - 2000;
		write_reg(REG_BASE, pick == 0 ? 32'h8000 : pick == 1 ? 32'h7FFF : {16'h0, b[15:0]});
		pick = $urandom_range(3);
		c1 = 12'($urandom_range(4095));
		c2 = 12'($urandom_range(4095));
		if (c1 > c2) begin t = c1; c1 = c2; c2 = t; end
		write_reg(REG_VALID_WIN, pick == 0 ? VALID_WIN_RST : pick == 1 ? 32'h7FFF_8000 :
			{16'(code_to_pressure(c2)), 16'(code_to_pressure(c1))});
		pick = $urandom_range(3);
		write_reg(REG_FAULT_LIMIT, pick == 3 ? $urandom_range(1, 8) : pick + 1);
		for (int k = 0; k < GAUGES; k++) begin
			c1 = 12'($urandom_range(4095));
			c2 = 12'($urandom_range(4095));
			if ((c1 > c2) == ($urandom_range(4) != 0)) begin t = c1; c1 = c2; c2 = t; end
			lo_code[k] = c1;
			hi_code[k] = c2;
			write_reg(REG_THR_GAUGE0 + 3'(k),
				{16'(code_to_pressure(c2)), 16'(code_to_pressure(c1))});
		end
		total = 0;
		while (total < n_items) begin
			if ($urandom_range(99) < 12) begin
				add_item(2'($urandom_range(3)), 12'($urandom_range(4095)),
					1'($urandom_range(1)));
				total++;
			end else begin
				g = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
				region = $urandom_range(3);
				len = $urandom_range(1, int'(cfg_limit) + 2);
				for (int i = 0; i < len; i++)
					add_item(g, pick_code(g, region), $urandom_range(9) != 0);
				total += len;
			end
		end
		if (squeeze)
			hold_requests++;
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: both thresholds at zero
		add_item(2'd0, 12'd0, 1'b1);
		add_item(2'd0, 12'hFFF, 1'b1);
		add_item(2'd1, 12'hFFF, 1'b0);
		add_item(2'd3, 12'd5, 1'b1);
		wait_drained();

		write_reg(REG_ZERO_CODE, 32'd2048);
		write_reg(REG_SLOPE_Q8, 32'd256);
		write_reg(REG_BASE, 32'd0);
		write_reg(REG_VALID_WIN, 32'h03E8_FC18);
		write_reg(REG_FAULT_LIMIT, 32'd2);
		write_reg(REG_THR_GAUGE0, 32'h0064_FF9C);
		write_reg(REG_THR_GAUGE1, 32'hFF9C_0064);   // crossed
		write_reg(REG_THR_GAUGE2, 32'h0000_0000);
		add_item(2'd0, 12'd2048, 1'b1);
		add_item(2'd0, 12'd1948, 1'b1);
		add_item(2'd0, 12'd2148, 1'b1);
		add_item(2'd0, 12'd0, 1'b1);
		add_item(2'd0, 12'd0, 1'b1);
		add_item(2'd0, 12'd0, 1'b1);
		add_item(2'd0, 12'hFFF, 1'b1);
		add_item(2'd0, 12'hFFF, 1'b1);
		add_item(2'd0, 12'd2048, 1'b0);
		add_item(2'd0, 12'd2048, 1'b1);
		add_item(2'd1, 12'd2048, 1'b1);
		add_item(2'd1, 12'd2048, 1'b1);
		add_item(2'd2, 12'd2048, 1'b1);
		add_item(2'd2, 12'd2049, 1'b1);
		add_item(2'd2, 12'd2049, 1'b1);
		add_item(2'd3, 12'hFFF, 1'b1);
		wait_drained();

		write_reg(REG_FAULT_LIMIT, 32'd0);
		add_item(2'd0, 12'd0, 1'b1);
		add_item(2'd0, 12'd0, 1'b1);
		add_item(2'd1, 12'hFFF, 1'b1);
		wait_drained();

		// saturation at both ends
		write_reg(REG_ZERO_CODE, 32'd0);
		write_reg(REG_SLOPE_Q8, 32'hFFFF);
		write_reg(REG_BASE, 32'h7FFF);
		write_reg(REG_VALID_WIN, 32'h7FFF_8000);
		add_item(2'd0, 12'hFFF, 1'b1);
		add_item(2'd1, 12'd1, 1'b1);
		wait_drained();
		write_reg(REG_ZERO_CODE, 32'hFFF);
		write_reg(REG_BASE, 32'h8000);
		add_item(2'd0, 12'd0, 1'b1);
		add_item(2'd2, 12'hFFF, 1'b1);
		wait_drained();

		random_phase(70, MODE_FREE, 1'b1);
		random_phase(70, MODE_SLOW_SRC, 1'b0);
		random_phase(70, MODE_SLOW_SINK, 1'b0);
		random_phase(70, MODE_BOTH, 1'b0);
		random_phase(70, MODE_SLOW_SINK, 1'b0);
		random_phase(70, MODE_SLOW_SRC, 1'b0);

		// limit of 254: run a counter up to its top
		set_mode(MODE_BOTH);
		write_reg(REG_ZERO_CODE, 32'd2048);
		write_reg(REG_SLOPE_Q8, 32'd256);
		write_reg(REG_BASE, 32'd0);
		write_reg(REG_VALID_WIN, VALID_WIN_RST);
		write_reg(REG_FAULT_LIMIT, 32'd254);
		write_reg(REG_THR_GAUGE0, 32'h0064_FF9C);
		write_reg(REG_THR_GAUGE1, 32'h7FFF_8000);
		write_reg(REG_THR_GAUGE2, 32'hFF9C_0064);
		for (int i = 0; i < 258; i++) begin
			add_item(2'd0, 12'd0, 1'b1);
			if (i % 8 == 0)
				add_item(2'($urandom_range(1, 2)), 12'($urandom_range(4095)), 1'b1);
		end
		repeat (3) add_item(2'd0, 12'hFFF, 1'b1);
		wait_drained();

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
